### rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg: shared types and constants for the box overlap unit
// Field widths, register indexes and per-axis data types.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int CenterWidth = 20;
   localparam int AxisWidth   = 16;
   localparam int HalfWidth   = 16;
   localparam int NumAxes     = 15;
   localparam int CellCount   = 15;
   localparam int CsrAddrWidth = 4;
   localparam logic [15:0] HalfReset = 16'd128;

   typedef enum logic [1:0] {
      REG_A_HALF_X = 2'd0,
      REG_A_HALF_Y = 2'd1,
      REG_A_HALF_Z = 2'd2
   } reg_index_type;

   typedef logic signed [AxisWidth-1:0]   comp_type;
   typedef comp_type [2:0]                vec_type;
   typedef logic signed [CenterWidth:0]   diff_type;
   typedef diff_type [2:0]                dvec_type;
   typedef logic [2:0] [HalfWidth-1:0]    half_type;

   // item carried down the cell row
   typedef struct packed {
      logic       valid;
      logic       sep;
      dvec_type   d;
      vec_type    a0;
      vec_type    a1;
      vec_type    a2;
      vec_type    b0;
      vec_type    b1;
      vec_type    b2;
      half_type   ea;
      half_type   eb;
   } item_type;

endpackage

### rtl/obb_cell.sv
// ----------------------------------------------------------------------------
// obb_cell: one separating axis test stage
// Tests one axis of the fifteen over three register stages and hands the
// item to its neighbor each cycle.
// ----------------------------------------------------------------------------
module obb_cell #(
   parameter int AxisSel = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  obb_pkg::item_type  item_in,
   output obb_pkg::item_type  item_out
);

   localparam int Ii = (AxisSel >= 6) ? (AxisSel - 6) / 3 : 0;
   localparam int Jj = (AxisSel >= 6) ? (AxisSel - 6) % 3 : 0;
   localparam int FaceSel = (AxisSel < 6) ? AxisSel : 0;

   obb_pkg::item_type s1_ff, s2_ff, s3_ff;
   obb_pkg::item_type s1_in;

   logic signed [32:0] ax_in [3];
   logic signed [32:0] ax_ff [3];
   logic signed [55:0] pr_in [7];
   logic signed [55:0] pr_ff [7];
   logic [63:0]        l_ff;
   logic [63:0]        r_ff;
   logic [48:0]        t_in [6];
   logic [63:0]        l_in;
   logic [63:0]        r_in;
   logic [15:0]        hw [6];

   function automatic obb_pkg::vec_type pick(input obb_pkg::item_type t, input int s);
      obb_pkg::vec_type v;
      unique case (s)
         0: v = t.a0;
         1: v = t.a1;
         2: v = t.a2;
         3: v = t.b0;
         4: v = t.b1;
         default: v = t.b2;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] mul_aa(input obb_pkg::comp_type x,
                                                 input obb_pkg::comp_type y);
      return x * y;
   endfunction

   function automatic logic signed [48:0] mul_ae(input logic signed [32:0] x,
                                                 input obb_pkg::comp_type y);
      return x * y;
   endfunction

   function automatic logic signed [53:0] mul_ad(input logic signed [32:0] x,
                                                 input obb_pkg::diff_type y);
      return x * y;
   endfunction

   function automatic logic [48:0] mul_rh(input logic [32:0] x, input logic [15:0] h);
      return x * h;
   endfunction

   function automatic logic [55:0] mag(input logic signed [55:0] v);
      return v[55] ? 56'(-v) : 56'(v);
   endfunction

   // stage 1: axis vector
   always_comb begin
      obb_pkg::vec_type va, vb;
      s1_in = item_in;
      va = '0;
      vb = '0;
      ax_in[0] = '0; ax_in[1] = '0; ax_in[2] = '0;
      if (AxisSel < 6) begin
         va = pick(item_in, FaceSel);
         for (int k = 0; k < 3; k++) ax_in[k] = 33'(signed'(va[k]));
      end else begin
         va = pick(item_in, Ii);
         vb = pick(item_in, 3 + Jj);
         ax_in[0] = 33'(mul_aa(va[1], vb[2])) - 33'(mul_aa(va[2], vb[1]));
         ax_in[1] = 33'(mul_aa(va[2], vb[0])) - 33'(mul_aa(va[0], vb[2]));
         ax_in[2] = 33'(mul_aa(va[0], vb[1])) - 33'(mul_aa(va[1], vb[0]));
      end
   end

   // stage 2: dot products of the axis with d and the six box axes
   always_comb begin
      obb_pkg::vec_type e;
      for (int k = 0; k < 6; k++) begin
         e = pick(s1_ff, k);
         pr_in[k] = 56'(mul_ae(ax_ff[0], e[0])) + 56'(mul_ae(ax_ff[1], e[1]))
                  + 56'(mul_ae(ax_ff[2], e[2]));
      end
      pr_in[6] = 56'(mul_ad(ax_ff[0], s1_ff.d[0])) + 56'(mul_ad(ax_ff[1], s1_ff.d[1]))
               + 56'(mul_ad(ax_ff[2], s1_ff.d[2]));
   end

   // stage 3: length and radius sum
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hw[k]   = s2_ff.ea[k];
         hw[k+3] = s2_ff.eb[k];
      end
      for (int k = 0; k < 6; k++) t_in[k] = '0;
      if (AxisSel < 6) begin
         l_in = 64'(mag(pr_ff[6])) << 15;
         r_in = 64'(hw[FaceSel]) << 30;
         for (int k = 0; k < 3; k++) begin
            if (AxisSel < 3) t_in[k] = mul_rh(33'(mag(pr_ff[3+k])), hw[3+k]);
            else             t_in[k] = mul_rh(33'(mag(pr_ff[k])), hw[k]);
         end
      end else begin
         l_in = 64'(mag(pr_ff[6]));
         r_in = '0;
         for (int k = 0; k < 3; k++) begin
            if (k != Ii) t_in[k]   = mul_rh(33'(mag(pr_ff[k]) >> 15), hw[k]);
            if (k != Jj) t_in[k+3] = mul_rh(33'(mag(pr_ff[3+k]) >> 15), hw[3+k]);
         end
      end
      for (int k = 0; k < 6; k++) r_in = r_in + 64'(t_in[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
         s2_ff.valid <= s1_ff.valid;
         s3_ff.valid <= s2_ff.valid;
      end
      s1_ff[$bits(s1_ff)-2:0] <= s1_in[$bits(s1_in)-2:0];
      s2_ff[$bits(s2_ff)-2:0] <= s1_ff[$bits(s1_ff)-2:0];
      s3_ff[$bits(s3_ff)-2:0] <= s2_ff[$bits(s2_ff)-2:0];
      ax_ff <= ax_in;
      pr_ff <= pr_in;
      l_ff  <= l_in;
      r_ff  <= r_in;
   end

   always_comb begin
      item_out = s3_ff;
      item_out.sep = s3_ff.sep | (l_ff > r_ff);
   end

endmodule

### rtl/obb_overlap_separating_axis_test_unit.sv
// ----------------------------------------------------------------------------
// obb_overlap_separating_axis_test_unit: oriented box overlap test
// ----------------------------------------------------------------------------
// Usage: write box A half extents on the psel/paddr port (x, y, z at byte addresses
// 0, 4, 8; each reset to 0.5). Pulse start with one box pair on the req_
// ports; busy is always low, so a pair is accepted every cycle.
// The item enters a row of fifteen cells, one per separating axis, each
// three register stages deep. The result is registered once more after the
// row and leaves on rsp_overlap, marked by rsp_valid for one cycle; one result
// per cycle sustained. The receiver cannot stall. Reset empties the row.
// ----------------------------------------------------------------------------
module obb_overlap_separating_axis_test_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [59:0]                       req_a_center,
   input  logic [59:0]                       req_b_center,
   input  logic [47:0]                       req_a_right,
   input  logic [47:0]                       req_a_up,
   input  logic [47:0]                       req_a_front,
   input  logic [47:0]                       req_b_right,
   input  logic [47:0]                       req_b_up,
   input  logic [47:0]                       req_b_front,
   input  logic [47:0]                       req_b_half,
   output logic                              rsp_valid,
   output logic                              rsp_overlap,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [obb_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic [15:0] half_ff [3];
   obb_pkg::item_type head_in;
   obb_pkg::item_type row [obb_pkg::CellCount+1];
   logic out_valid_ff, out_ovl_ff;
   logic wr;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff[0] <= obb_pkg::HalfReset;
         half_ff[1] <= obb_pkg::HalfReset;
         half_ff[2] <= obb_pkg::HalfReset;
      end else if (wr && paddr[1:0] == 2'b00) begin
         unique case (paddr[3:2])
            obb_pkg::REG_A_HALF_X: half_ff[0] <= pwdata[15:0];
            obb_pkg::REG_A_HALF_Y: half_ff[1] <= pwdata[15:0];
            obb_pkg::REG_A_HALF_Z: half_ff[2] <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         obb_pkg::REG_A_HALF_X: prdata = {16'd0, half_ff[0]};
         obb_pkg::REG_A_HALF_Y: prdata = {16'd0, half_ff[1]};
         obb_pkg::REG_A_HALF_Z: prdata = {16'd0, half_ff[2]};
         default:               prdata = '0;
      endcase
   end

   always_comb begin
      head_in.valid = start & ~busy;
      head_in.sep   = 1'b0;
      for (int k = 0; k < 3; k++) begin
         head_in.d[k] = 21'(signed'(req_a_center[20*k +: 20]))
                      - 21'(signed'(req_b_center[20*k +: 20]));
         head_in.a0[k] = req_a_right[16*k +: 16];
         head_in.a1[k] = req_a_up[16*k +: 16];
         head_in.a2[k] = req_a_front[16*k +: 16];
         head_in.b0[k] = req_b_right[16*k +: 16];
         head_in.b1[k] = req_b_up[16*k +: 16];
         head_in.b2[k] = req_b_front[16*k +: 16];
         head_in.eb[k] = req_b_half[16*k +: 16];
         head_in.ea[k] = half_ff[k];
      end
   end

   assign row[0] = head_in;

   for (genvar g = 0; g < obb_pkg::CellCount; g++) begin : g_cell
      obb_cell #(.AxisSel(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .item_in  (row[g]),
         .item_out (row[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= row[obb_pkg::CellCount].valid;
      out_ovl_ff <= ~row[obb_pkg::CellCount].sep;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_overlap = out_ovl_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      (wr && paddr[1:0] == 2'b00 && paddr[3:2] == obb_pkg::REG_A_HALF_X)
      |=> half_ff[0] == $past(pwdata[15:0]))
      else $error("csr write lost");

endmodule
